@@ hw/rtl/sit_pkg.sv @@
// Shared types and constants for the sorted interval table.
// No dependencies; imported by the interfaces and the core, not by sit_ram.
`timescale 1ns / 1ps

package sit_pkg;

   localparam int ADDR_W       = 48;
   localparam int TAG_W        = 64;
   localparam int STATUS_W     = 3;
   localparam int OP_W         = 2;
   localparam int DEF_CAPACITY = 64;

   typedef enum logic [OP_W-1:0] {
      OP_REGISTER = 2'd0,
      OP_REMOVE   = 2'd1,
      OP_FIND     = 2'd2,
      OP_UNUSED   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 3'd0,
      ST_EMPTY = 3'd1,
      ST_CLASH = 3'd2,
      ST_FULL  = 3'd3,
      ST_MISS  = 3'd4
   } status_type;

   // One stored range with its three tags.
   typedef struct packed {
      logic [ADDR_W-1:0] start_addr;
      logic [ADDR_W-1:0] end_addr;
      logic [TAG_W-1:0]  function_tag;
      logic [TAG_W-1:0]  header_tag;
      logic [TAG_W-1:0]  resume_tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

@@ hw/rtl/sit_req_if.sv @@
// Request channel of the sorted interval table: valid/ready plus one request beat.
// Depends on sit_pkg for the field widths.
`timescale 1ns / 1ps

interface sit_req_if import sit_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [ADDR_W-1:0]   range_start;
   logic [ADDR_W-1:0]   range_end;
   logic [TAG_W-1:0]    function_tag;
   logic [TAG_W-1:0]    header_tag;
   logic [TAG_W-1:0]    resume_tag;

   modport source (output valid, operation, range_start, range_end,
                   function_tag, header_tag, resume_tag, input ready);
   modport sink   (input valid, operation, range_start, range_end,
                   function_tag, header_tag, resume_tag, output ready);

endinterface

@@ hw/rtl/sit_rsp_if.sv @@
// Response channel of the sorted interval table: valid/ready plus one result beat.
// Depends on sit_pkg for the field widths.
`timescale 1ns / 1ps

interface sit_rsp_if import sit_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   hit_start;
   logic [ADDR_W-1:0]   hit_end;
   logic [TAG_W-1:0]    hit_function_tag;
   logic [TAG_W-1:0]    hit_header_tag;
   logic [TAG_W-1:0]    hit_resume_tag;

   modport source (output valid, status, hit_start, hit_end, hit_function_tag,
                   hit_header_tag, hit_resume_tag, input ready);
   modport sink   (input valid, status, hit_start, hit_end, hit_function_tag,
                   hit_header_tag, hit_resume_tag, output ready);

endinterface

@@ hw/rtl/sit_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sit_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/sorted_interval_table_core.sv @@
// Top level of the sorted interval table: sequencer around one range memory.
// Depends on sit_pkg, sit_req_if, sit_rsp_if and sit_ram.
`timescale 1ns / 1ps

// The block keeps up to CAPACITY non-overlapping half-open ranges [start, end),
// sorted by start, each with three opaque tags, in one synchronous RAM.
// A request beat on req_bus carries an operation: register a range, remove the
// range that starts exactly at an address, or find the range that holds an
// address. Every request produces exactly one response beat on rsp_bus with a
// status and, for a find that hits, the stored range and its tags.
// One request is worked on at a time. The block takes a beat in its idle
// state, then runs a binary search over the RAM in which each probe issues
// the address in S_SEARCH and compares the registered read data in
// S_COMPARE, then fetches the neighbor entries and decides in S_FETCH_CUR,
// S_FETCH_PRV and S_DECIDE. A register or remove that changes the table then
// moves the entries behind the insertion point one slot a cycle through the
// RAM's single read and write port. The response sits in an output register;
// the block accepts the next request while it waits, and only stalls if a
// second response is ready before the receiver takes the first. Reset
// (synchronous) empties the table by clearing the entry count; the RAM
// content needs no clearing because only entries below the count are ever
// used.

module sorted_interval_table_core import sit_pkg::*; #(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic clock,
   input  logic reset,
   sit_req_if.sink   req_bus,
   sit_rsp_if.source rsp_bus
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_SEARCH    = 8'b0000_0010,
      S_COMPARE   = 8'b0000_0100,
      S_FETCH_CUR = 8'b0000_1000,
      S_FETCH_PRV = 8'b0001_0000,
      S_DECIDE    = 8'b0010_0000,
      S_SHIFT     = 8'b0100_0000,
      S_RESPOND   = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Request held for the whole operation.
   op_type           op_ff, op_in;
   entry_type        new_ff, new_in;

   // Binary search bounds; lo ends as the first index whose start is not below the key.
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] mid_calc;
   entry_type        cur_ff, cur_in;

   // Entry move engine: overlaps the read of one entry with the write of the entry read before.
   logic [IDX_W-1:0] src_ff, src_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             up_ff, up_in;
   logic             wr_pend_ff, wr_pend_in;
   logic [IDX_W-1:0] wr_addr_ff, wr_addr_in;

   // Result of the current operation and the output register.
   status_type       stat_ff, stat_in;
   entry_type        hit_ff, hit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_stat_ff, rsp_stat_in;
   entry_type        rsp_hit_ff, rsp_hit_in;

   // RAM ports.
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [IDX_W-1:0] ram_raddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type        rd_entry;

   logic             req_fire;
   logic             has_cur;
   logic             has_prv;
   logic             rsp_free;

   sit_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_entry = entry_type'(ram_rdata);

   // No beat is taken while reset is held.
   assign req_bus.ready = (state_ff == S_IDLE) && !reset;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign has_cur  = (lo_ff < count_ff);
   assign has_prv  = (lo_ff != '0);
   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      new_in       = new_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      cur_in       = cur_ff;
      src_in       = src_ff;
      left_in      = left_ff;
      up_in        = up_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      stat_in      = stat_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_stat_in  = rsp_stat_ff;
      rsp_hit_in   = rsp_hit_ff;

      ram_raddr = '0;
      ram_we    = 1'b0;
      ram_waddr = wr_addr_ff;
      ram_wdata = ram_rdata;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in               = op_type'(req_bus.operation);
               new_in.start_addr   = req_bus.range_start;
               new_in.end_addr     = req_bus.range_end;
               new_in.function_tag = req_bus.function_tag;
               new_in.header_tag   = req_bus.header_tag;
               new_in.resume_tag   = req_bus.resume_tag;
               lo_in               = '0;
               hi_in               = count_ff;
               state_in            = S_SEARCH;
            end
         end

         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               mid_in    = mid_calc[IDX_W-1:0];
               ram_raddr = mid_calc[IDX_W-1:0];
               state_in  = S_COMPARE;
            end else begin
               state_in = S_FETCH_CUR;
            end
         end

         S_COMPARE: begin
            if (rd_entry.start_addr < new_ff.start_addr) begin
               lo_in = CNT_W'(mid_ff) + CNT_W'(1);
            end else begin
               hi_in = CNT_W'(mid_ff);
            end
            state_in = S_SEARCH;
         end

         S_FETCH_CUR: begin
            // Only read below the count; otherwise the data is ignored.
            ram_raddr = has_cur ? lo_ff[IDX_W-1:0] : '0;
            state_in  = S_FETCH_PRV;
         end

         S_FETCH_PRV: begin
            cur_in    = rd_entry;
            ram_raddr = has_prv ? IDX_W'(lo_ff - CNT_W'(1)) : '0;
            state_in  = S_DECIDE;
         end

         S_DECIDE: begin
            // Read data now holds the entry before the search point.
            hit_in   = '0;
            stat_in  = ST_MISS;
            state_in = S_RESPOND;
            case (op_ff)
               OP_REGISTER: begin
                  if (new_ff.start_addr >= new_ff.end_addr) begin
                     stat_in = ST_EMPTY;
                  end else if (has_cur && cur_ff.start_addr == new_ff.start_addr) begin
                     stat_in = ST_CLASH;
                  end else if (has_cur && new_ff.end_addr > cur_ff.start_addr) begin
                     stat_in = ST_CLASH;
                  end else if (has_prv && new_ff.start_addr < rd_entry.end_addr) begin
                     stat_in = ST_CLASH;
                  end else if (count_ff >= CAP_CNT) begin
                     stat_in = ST_FULL;
                  end else begin
                     // Open a slot at the search point by moving the tail up.
                     stat_in  = ST_OK;
                     up_in    = 1'b1;
                     left_in  = count_ff - lo_ff;
                     src_in   = IDX_W'(count_ff - CNT_W'(1));
                     state_in = S_SHIFT;
                  end
               end
               OP_REMOVE: begin
                  if (has_cur && cur_ff.start_addr == new_ff.start_addr) begin
                     // Close the gap by moving the tail down.
                     stat_in  = ST_OK;
                     up_in    = 1'b0;
                     left_in  = count_ff - lo_ff - CNT_W'(1);
                     src_in   = IDX_W'(lo_ff + CNT_W'(1));
                     state_in = S_SHIFT;
                  end
               end
               OP_FIND: begin
                  if (has_cur && cur_ff.start_addr == new_ff.start_addr) begin
                     stat_in = ST_OK;
                     hit_in  = cur_ff;
                  end else if (has_prv && new_ff.start_addr >= rd_entry.start_addr &&
                               new_ff.start_addr < rd_entry.end_addr) begin
                     stat_in = ST_OK;
                     hit_in  = rd_entry;
                  end
               end
               default: begin
                  stat_in = ST_MISS;
               end
            endcase
         end

         S_SHIFT: begin
            // Retire the write of the entry read in the previous cycle.
            if (wr_pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = wr_addr_ff;
               ram_wdata = ram_rdata;
            end
            if (left_ff != '0) begin
               ram_raddr  = src_ff;
               wr_pend_in = 1'b1;
               wr_addr_in = up_ff ? (src_ff + IDX_W'(1)) : (src_ff - IDX_W'(1));
               src_in     = up_ff ? (src_ff - IDX_W'(1)) : (src_ff + IDX_W'(1));
               left_in    = left_ff - CNT_W'(1);
            end else if (!wr_pend_ff) begin
               // Move done: place the new range, or just drop the last slot.
               if (up_ff) begin
                  ram_we    = 1'b1;
                  ram_waddr = lo_ff[IDX_W-1:0];
                  ram_wdata = new_ff;
                  count_in  = count_ff + CNT_W'(1);
               end else begin
                  count_in  = count_ff - CNT_W'(1);
               end
               state_in = S_RESPOND;
            end
         end

         S_RESPOND: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = stat_ff;
               rsp_hit_in   = hit_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      new_ff      <= new_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      cur_ff      <= cur_in;
      src_ff      <= src_in;
      left_ff     <= left_in;
      up_ff       <= up_in;
      wr_addr_ff  <= wr_addr_in;
      stat_ff     <= stat_in;
      hit_ff      <= hit_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_hit_ff  <= rsp_hit_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.status           = rsp_stat_ff;
   assign rsp_bus.hit_start        = rsp_hit_ff.start_addr;
   assign rsp_bus.hit_end          = rsp_hit_ff.end_addr;
   assign rsp_bus.hit_function_tag = rsp_hit_ff.function_tag;
   assign rsp_bus.hit_header_tag   = rsp_hit_ff.header_tag;
   assign rsp_bus.hit_resume_tag   = rsp_hit_ff.resume_tag;

endmodule
